### design/lnc_pkg.sv
package lnc_pkg;

	localparam int unsigned NAME_BYTES = 20;
	localparam int unsigned NAME_CHARS = 20;
	localparam int unsigned CAPACITY_DEF = 32;
	localparam int unsigned SIZE_W = 6;
	localparam int unsigned TOTAL_W = 32;
	localparam logic [TOTAL_W-1:0] COST_HIT = 32'd1;
	localparam logic [TOTAL_W-1:0] COST_MISS = 32'd5;

	// stored name, head in the low bits
	typedef struct packed {
		logic [31:0] tail;
		logic [63:0] middle;
		logic [63:0] head;
	} tag_t;

	// per-cell control from the sequencer
	typedef struct packed {
		logic cmp_en;
		logic shift_en;
		logic valid;
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD
	} state_t;

	// cut at the first zero byte, fold a..z to upper case
	function automatic tag_t fold_name(logic [63:0] h, logic [63:0] m, logic [31:0] t);
		logic [8*NAME_BYTES-1:0] raw;
		logic [8*NAME_BYTES-1:0] res;
		logic ended;
		logic [7:0] b;
		raw = {t, m, h};
		res = '0;
		ended = 1'b0;
		for (int k = 0; k < NAME_BYTES; k++) begin
			b = raw[8*k +: 8];
			if (k >= NAME_CHARS || ended) begin
				b = 8'h00;
			end
			if (b == 8'h00) begin
				ended = 1'b1;
			end
			if (b inside {[8'h61:8'h7a]}) begin
				b = b - 8'h20;
			end
			res[8*k +: 8] = b;
		end
		return tag_t'(res);
	endfunction

endpackage

### design/lru_name_cache_top.sv
// lru_name_cache_top: fully associative lru cache of names
// an item runs ST_CMP then ST_UPD; done and hit are registered at the end of ST_UPD
// one item at a time, busy while in work: fold, compare in all cells, shift the row
// the receiver cannot stall: each result shows on done for one cycle only
// reset (arst_n low, async) empties the cache, clears the total and cache_size
module lru_name_cache_top
	import lnc_pkg::*;
#(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [63:0]          name_head,
	input  logic [63:0]          name_middle,
	input  logic [31:0]          name_tail,
	input  logic                 cfg_we,
	input  logic [SIZE_W-1:0]    cfg_wdata,
	output logic                 done,
	output logic                 hit,
	output logic [TOTAL_W-1:0]   total_time
);

	localparam int unsigned CW = $clog2(CAPACITY + 1);

	// sequencer and bookkeeping
	state_t               state_q;
	state_t               state_d;
	logic [SIZE_W-1:0]    cache_size_q;
	logic [CW-1:0]        entry_count_q;
	logic [TOTAL_W-1:0]   total_q;
	tag_t                 name_q;
	logic                 done_q;
	logic                 hit_q;

	// row of cells: position 0 is most recent, entry_count_q-1 least recent
	tag_t                 tags [CAPACITY];
	logic [CAPACITY:0]    found;
	logic [CAPACITY-1:0]  match_vec;
	cell_ctrl_t           ctrl [CAPACITY];

	logic                 lookup_hit;
	logic [CW-1:0]        cap;
	logic                 full;
	logic                 insert;
	logic [CW:0]          limit;
	logic [TOTAL_W:0]     sum;

	assign found[0] = 1'b0;
	assign lookup_hit = found[CAPACITY];

	// cache_size above capacity acts as capacity
	assign cap = ({26'd0, cache_size_q} > 32'(CAPACITY)) ? CW'(CAPACITY)
	                                                     : CW'({26'd0, cache_size_q});
	// full also covers a shrunk register: then the count stays put
	assign full = (entry_count_q >= cap);
	assign insert = !lookup_hit && (cap != '0);
	// on an insert (a miss with a nonzero size) the cells below limit shift down one place
	assign limit = full ? {1'b0, entry_count_q} : ({1'b0, entry_count_q} + 1'b1);

	// saturating cost add
	assign sum = {1'b0, total_q} + {1'b0, (lookup_hit ? COST_HIT : COST_MISS)};

	generate
		for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
			always_comb begin
				ctrl[i].cmp_en = (state_q == ST_CMP);
				ctrl[i].valid = ((CW+1)'(i) < {1'b0, entry_count_q});
				if (state_q != ST_UPD) begin
					ctrl[i].shift_en = 1'b0;
				end else if (i == 0) begin
					// head cell takes the new name on a hit or an insert
					ctrl[i].shift_en = lookup_hit || insert;
				end else if (lookup_hit) begin
					// cells above and at the hit position move down
					ctrl[i].shift_en = !found[i];
				end else begin
					ctrl[i].shift_en = insert && ((CW+1)'(i) < limit);
				end
			end

			lnc_cell u_cell (
				.clk       (clk),
				.ctrl      (ctrl[i]),
				.key       (name_q),
				.din       ((i == 0) ? name_q : tags[(i == 0) ? 0 : i - 1]),
				.found_in  (found[i]),
				.tag       (tags[i]),
				.match     (match_vec[i]),
				.found_out (found[i+1])
			);
		end
	endgenerate

	// next state and busy
	always_comb begin
		state_d = state_q;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				state_d = ST_UPD;
			end
			ST_UPD: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cache_size_q <= '0;
			entry_count_q <= '0;
			total_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == ST_UPD);
			if (cfg_we) begin
				cache_size_q <= cfg_wdata;
			end
			if (state_q == ST_UPD) begin
				total_q <= sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
				if (insert && !full) begin
					entry_count_q <= entry_count_q + 1'b1;
				end
			end
		end
	end

	// item payload and result registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			name_q <= fold_name(name_head, name_middle, name_tail);
		end
		if (state_q == ST_UPD) begin
			hit_q <= lookup_hit;
		end
	end

	assign done = done_q;
	assign hit = hit_q;
	assign total_time = total_q;

	// stored names are unique, so at most one cell can match
	a_one_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) |-> $onehot0(match_vec))
		else $error("more than one cell matched");

	// the fill count never passes the row length
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, entry_count_q} <= (CW+1)'(CAPACITY))
		else $error("entry count beyond capacity");

	// every accepted item gives its result strobe on done
	a_result_timing: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("result strobe missing");

	// the total never goes down while the cache runs
	a_total_grows: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (total_time > $past(total_time) || total_time == '1))
		else $error("total did not grow");

endmodule

### design/lnc_cell.sv
module lnc_cell
	import lnc_pkg::*;
(
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  tag_t       key,
	input  tag_t       din,
	input  logic       found_in,
	output tag_t       tag,
	output logic       match,
	output logic       found_out
);

	tag_t tag_q;
	logic match_q;

	always_ff @(posedge clk) begin
		if (ctrl.cmp_en) begin
			match_q <= ctrl.valid && (tag_q == key);
		end
		if (ctrl.shift_en) begin
			tag_q <= din;
		end
	end

	// found travels down the row: set once this cell or any more recent cell matched
	assign found_out = found_in | match_q;
	assign match = match_q;
	assign tag = tag_q;

endmodule

### verif/lru_name_cache_top_tb.sv
module lru_name_cache_top_tb
	import lnc_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam time HALF_PERIOD = 5ns;
	localparam int unsigned RESET_CYCLES = 9;
	// leave margin after the result strobe before a size write
	localparam int unsigned SETTLE = 6;
	localparam int unsigned TAIL_CYCLES = 12;
	localparam int unsigned CYCLE_LIMIT = 250000;
	localparam int unsigned ITEMS_PER_PHASE = 160;
	localparam int unsigned POOL_NAMES = 48;

	// what the driver pulls off its queue
	typedef enum logic [1:0] {
		FEED_NAME,
		FEED_SIZE,
		FEED_DRAIN
	} feed_kind_t;

	typedef struct {
		feed_kind_t        kind;
		logic [159:0]      name;
		logic [SIZE_W-1:0] size;
		int unsigned       gap;
	} feed_t;

	// one predicted lookup result
	typedef struct {
		logic               hit;
		logic [TOTAL_W-1:0] total;
	} lookup_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [63:0]        name_head = '0;
	logic [63:0]        name_middle = '0;
	logic [31:0]        name_tail = '0;
	logic               cfg_we = 1'b0;
	logic [SIZE_W-1:0]  cfg_wdata = '0;
	logic               done;
	logic               hit;
	logic [TOTAL_W-1:0] total_time;

	feed_t        name_feed[$];
	lookup_t      due_lookups[$];
	logic [159:0] name_pool[$];

	// handshake bookkeeping shared between the edges
	logic        accepted = 1'b0;
	int unsigned quiet = 0;
	int unsigned idle_cnt = 0;
	int unsigned err_cnt = 0;
	int unsigned cycles = 0;

	// shadow of the cache: stored names, age (0 = most recent), fill level, cost
	tag_t               slot_name[CAPACITY_DEF];
	int unsigned        slot_age[CAPACITY_DEF];
	int unsigned        live_slots = 0;
	logic [TOTAL_W-1:0] cost_sum = '0;
	logic [SIZE_W-1:0]  size_reg = '0;

	lru_name_cache_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.name_head   (name_head),
		.name_middle (name_middle),
		.name_tail   (name_tail),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.done        (done),
		.hit         (hit),
		.total_time  (total_time)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// name as the cache sees it: cut at the first nul, letters raised to capitals
	function automatic tag_t upcase_name(logic [159:0] raw);
		logic [159:0] res;
		logic [7:0] ch;
		logic over;
		res = '0;
		over = 1'b0;
		for (int k = 0; k < NAME_BYTES; k++) begin
			ch = raw[8*k +: 8];
			if (over || k >= NAME_CHARS) begin
				ch = 8'h00;
			end
			over = over || (ch == 8'h00);
			if (ch >= 8'h61 && ch <= 8'h7a) begin
				ch = ch ^ 8'h20;
			end
			res[8*k +: 8] = ch;
		end
		return tag_t'(res);
	endfunction

	// one lookup against the shadow cache, updates ages, contents and cost
	function automatic lookup_t lru_lookup(tag_t key);
		lookup_t res;
		int unsigned lim;
		int unsigned slot;
		int unsigned old_age;
		logic found;
		logic [TOTAL_W:0] sum;
		lim = (size_reg > CAPACITY_DEF) ? CAPACITY_DEF : size_reg;
		found = 1'b0;
		slot = 0;
		for (int unsigned i = 0; i < live_slots; i++) begin
			if (!found && slot_name[i] == key) begin
				found = 1'b1;
				slot = i;
			end
		end
		if (found) begin
			// everything younger than the hit entry ages by one
			old_age = slot_age[slot];
			for (int unsigned i = 0; i < live_slots; i++) begin
				if (slot_age[i] < old_age) begin
					slot_age[i]++;
				end
			end
			slot_age[slot] = 0;
			sum = {1'b0, cost_sum} + COST_HIT;
		end else begin
			sum = {1'b0, cost_sum} + COST_MISS;
			if (lim != 0) begin
				if (live_slots >= lim) begin
					// full or shrunk: reuse the oldest entry
					for (int unsigned i = 0; i < live_slots; i++) begin
						if (slot_age[i] == live_slots - 1) begin
							slot = i;
						end
					end
				end else begin
					slot = live_slots;
					live_slots++;
				end
				for (int unsigned i = 0; i < live_slots; i++) begin
					if (i != slot) begin
						slot_age[i]++;
					end
				end
				slot_name[slot] = key;
				slot_age[slot] = 0;
			end
		end
		cost_sum = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
		res.hit = found;
		res.total = cost_sum;
		return res;
	endfunction

	task automatic report(string msg);
		err_cnt++;
		$display("%0t mismatch: %s", $time, msg);
	endtask

	// ascii text to the port layout, first character in the low byte
	function automatic logic [159:0] text_name(string s);
		logic [159:0] v;
		v = '0;
		for (int k = 0; k < s.len() && k < NAME_BYTES; k++) begin
			v[8*k +: 8] = s[k];
		end
		return v;
	endfunction

	// same name with random letter case and, sometimes, junk after the nul
	function automatic logic [159:0] vary_case(logic [159:0] base);
		logic [159:0] v;
		logic [7:0] ch;
		logic ended;
		logic junk;
		v = base;
		ended = 1'b0;
		junk = 1'($urandom_range(0, 1));
		for (int k = 0; k < NAME_BYTES; k++) begin
			ch = v[8*k +: 8];
			if (ended) begin
				if (junk) begin
					ch = 8'($urandom_range(0, 255));
				end
			end else if (ch == 8'h00) begin
				ended = 1'b1;
			end else if (ch >= 8'h41 && ch <= 8'h5a && $urandom_range(0, 1)) begin
				ch = ch | 8'h20;
			end
			v[8*k +: 8] = ch;
		end
		return v;
	endfunction

	task automatic push_name(logic [159:0] v, int unsigned gap);
		feed_t f;
		f.kind = FEED_NAME;
		f.name = v;
		f.size = '0;
		f.gap = gap;
		name_feed.push_back(f);
	endtask

	task automatic push_ctrl(feed_kind_t kind, logic [SIZE_W-1:0] size);
		feed_t f;
		f.kind = kind;
		f.name = '0;
		f.size = size;
		f.gap = 0;
		name_feed.push_back(f);
	endtask

	// driver: inputs move on the falling edge only
	always @(negedge clk) begin
		logic go;
		logic we;
		feed_t head;
		go = start;
		we = 1'b0;
		if (arst_n) begin
			if (start && accepted) begin
				go = 1'b0;
			end
			// idle cycles with nothing outstanding, gates size writes and pauses
			quiet = (due_lookups.size() == 0 && !start) ? quiet + 1 : 0;
			if (!go && name_feed.size() != 0) begin
				head = name_feed[0];
				case (head.kind)
					FEED_NAME: begin
						if (idle_cnt < head.gap) begin
							idle_cnt++;
						end else begin
							head = name_feed.pop_front();
							idle_cnt = 0;
							go = 1'b1;
							name_head <= head.name[63:0];
							name_middle <= head.name[127:64];
							name_tail <= head.name[159:128];
						end
					end
					FEED_SIZE: begin
						if (quiet >= SETTLE) begin
							head = name_feed.pop_front();
							we = 1'b1;
							cfg_wdata <= head.size;
							quiet = 0;
						end
					end
					FEED_DRAIN: begin
						// hold off until every outstanding result is back
						if (quiet >= 1) begin
							head = name_feed.pop_front();
						end
					end
					default: begin
					end
				endcase
			end
		end
		start <= go;
		cfg_we <= we;
	end

	// monitor: handshakes and results sampled on the rising edge
	always @(posedge clk) begin
		lookup_t want;
		lookup_t seen;
		accepted = arst_n && start && !busy;
		if (arst_n) begin
			if (cfg_we) begin
				size_reg = cfg_wdata;
			end
			if (accepted) begin
				want = lru_lookup(upcase_name({name_tail, name_middle, name_head}));
				due_lookups.push_back(want);
			end
			if (done) begin
				seen.hit = hit;
				seen.total = total_time;
				if (due_lookups.size() == 0) begin
					report($sformatf("result with nothing outstanding: hit %0b total %0d",
						seen.hit, seen.total));
				end else begin
					want = due_lookups.pop_front();
					if (seen.hit !== want.hit) begin
						report($sformatf("hit %0b, wanted %0b", seen.hit, want.hit));
					end
					if (seen.total !== want.total) begin
						report($sformatf("total_time %0d, wanted %0d", seen.total, want.total));
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int unsigned phase_sizes[9];
		int unsigned len;
		int unsigned span;
		int unsigned lim;
		int unsigned pace;
		int unsigned gap;
		logic [159:0] v;

		// pool of names to draw from, mostly capitals, some arbitrary bytes
		for (int n = 0; n < POOL_NAMES; n++) begin
			v = '0;
			len = ($urandom_range(0, 3) == 0) ? NAME_BYTES : $urandom_range(1, NAME_BYTES);
			for (int k = 0; k < len; k++) begin
				v[8*k +: 8] = 8'(($urandom_range(0, 4) == 0) ? $urandom_range(1, 255)
					: 8'h41 + $urandom_range(0, 25));
			end
			name_pool.push_back(v);
		end

		// directed: size still at its reset value of zero, nothing is kept
		push_name(text_name("alice"), $urandom_range(0, 15));
		push_name(text_name("alice"), $urandom_range(0, 15));
		push_ctrl(FEED_SIZE, 6'd3);
		// empty name, miss then hit
		push_name('0, 0);
		push_name('0, 0);
		// every bit set, no nul anywhere
		push_name('1, $urandom_range(0, 15));
		// case folding and junk past the end of the name
		push_name(text_name("bob"), 0);
		push_name(text_name("BOB"), $urandom_range(0, 15));
		v = text_name("Bob");
		v[159:32] = {$urandom, $urandom, $urandom, $urandom};
		push_name(v, 0);
		// three 0xff bytes, a nul, then set bits: full cache, oldest goes
		v = '1;
		v[31:24] = 8'h00;
		push_name(v, 0);
		push_name('0, $urandom_range(0, 15));
		// longest name, both cases
		push_name(text_name("abcdefghijklmnopqrst"), 0);
		push_name(text_name("ABCDEFGHIJKLMNOPQRST"), 0);
		// bytes just outside the letter ranges must not fold
		push_name(text_name("`{@["), $urandom_range(0, 15));
		push_name(text_name("`{@["), 0);
		// size beyond the capacity acts as the capacity
		push_ctrl(FEED_SIZE, 6'd63);
		push_name(text_name("alice"), 0);
		push_name(text_name("ALICE"), 0);
		// single entry
		push_ctrl(FEED_SIZE, 6'd1);
		push_name(text_name("x"), 0);
		push_name(text_name("X"), 0);
		push_name(text_name("y"), $urandom_range(0, 15));
		push_name(text_name("x"), 0);

		// random phases; 63 after 32 keeps the cache full, 2 then shrinks it
		phase_sizes = '{32, 63, 2, 0, 1, 20, 5, 32, 0};
		phase_sizes[8] = $urandom_range(0, 63);
		foreach (phase_sizes[p]) begin
			push_ctrl(FEED_SIZE, SIZE_W'(phase_sizes[p]));
			lim = (phase_sizes[p] > CAPACITY_DEF) ? CAPACITY_DEF : phase_sizes[p];
			// a few more names than slots so hits and evictions both happen
			span = (lim == 0) ? 6 : lim + $urandom_range(1, lim / 2 + 2);
			if (span > POOL_NAMES) begin
				span = POOL_NAMES;
			end
			pace = p % 3;
			for (int j = 0; j < ITEMS_PER_PHASE; j++) begin
				if (j == ITEMS_PER_PHASE / 2 && p % 2 == 0) begin
					push_ctrl(FEED_DRAIN, '0);
				end
				case (pace)
					0: gap = 0;
					1: gap = $urandom_range(0, 15);
					default: gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0;
				endcase
				if ($urandom_range(0, 9) == 0) begin
					v = {$urandom, $urandom, $urandom, $urandom, $urandom};
				end else begin
					v = vary_case(name_pool[$urandom_range(0, span - 1)]);
				end
				push_name(v, gap);
			end
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// run until the feed is empty and every lookup has come back
		while (name_feed.size() != 0 || start || due_lookups.size() != 0) begin
			@(negedge clk);
		end
		repeat (TAIL_CYCLES) @(negedge clk);

		if (err_cnt == 0 && due_lookups.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

### sim.f
design/lnc_pkg.sv
design/lnc_cell.sv
design/lru_name_cache_top.sv
verif/lru_name_cache_top_tb.sv
